/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* src/dtcc_pkg.sv */
// ----------------------------------------------------------------------------
// dtcc_pkg
// Types, codes and decode helpers for the deflate tail completeness check.
// ----------------------------------------------------------------------------
package dtcc_pkg;

    localparam int TAIL_W = 39;
    localparam int CNT_W  = 6;

    // Verdict codes
    localparam logic [1:0] VERDICT_INCOMPLETE = 2'd0;
    localparam logic [1:0] VERDICT_COMPLETE   = 2'd1;
    localparam logic [1:0] VERDICT_ERROR      = 2'd2;

    // Block types
    localparam logic [1:0] BTYPE_STORED   = 2'd0;
    localparam logic [1:0] BTYPE_FIXED    = 2'd1;
    localparam logic [1:0] BTYPE_DYNAMIC  = 2'd2;
    localparam logic [1:0] BTYPE_RESERVED = 2'd3;

    localparam logic [8:0]       SYM_END_OF_BLOCK = 9'd256;
    localparam logic [8:0]       SYM_LEN_MAX      = 9'd285;
    localparam logic [4:0]       DIST_CODE_MAX    = 5'd29;
    localparam logic [31:0]      STORED_EMPTY     = 32'hFFFF_0000;
    localparam logic [CNT_W-1:0] STORED_MIN_BITS  = 6'h20;

    // Bit reader control and status
    typedef struct packed {
        logic load;
        logic take;
    } rd_ctrl_t;

    typedef struct packed {
        logic              cur_bit;
        logic [CNT_W-1:0]  remain;
        logic [TAIL_W-1:0] word;
    } rd_stat_t;

    // Walker status toward the stream shell
    typedef struct packed {
        logic       idle;
        logic       done;
        logic [1:0] verdict;
    } walk_stat_t;

    typedef struct packed {
        logic       hit;
        logic [8:0] sym;
    } sym_match_t;

    // Fixed Huffman literal/length code lookup, code read MSB first
    function automatic sym_match_t fixed_sym(input logic [8:0] code,
                                             input logic [3:0] nbits);
        sym_match_t r;
        r.hit = 1'b0;
        r.sym = '0;
        if (nbits == 4'd7 && code <= 9'h017) begin
            r.hit = 1'b1;
            r.sym = code + 9'd256;
        end else if (nbits == 4'd8 && code >= 9'h030 && code <= 9'h0BF) begin
            r.hit = 1'b1;
            r.sym = code - 9'h030;
        end else if (nbits == 4'd8 && code >= 9'h0C0 && code <= 9'h0C7) begin
            r.hit = 1'b1;
            r.sym = 9'd280 + (code - 9'h0C0);
        end else if (nbits == 4'd9 && code >= 9'h190) begin
            r.hit = 1'b1;
            r.sym = 9'h090 + (code - 9'h190);
        end
        return r;
    endfunction

    // Extra bits after a length symbol
    function automatic logic [3:0] length_extra(input logic [8:0] sym);
        logic [4:0] li;
        li = 5'(sym - 9'd257);
        if (li < 5'd8 || li == 5'd28)
            return 4'd0;
        return 4'((li - 5'd4) >> 2);
    endfunction

    // Extra bits after a distance code
    function automatic logic [3:0] dist_extra(input logic [4:0] dc);
        if (dc < 5'd4)
            return 4'd0;
        return 4'((dc >> 1) - 5'd1);
    endfunction

endpackage

/* src/dtcc_bit_reader.sv */
// ----------------------------------------------------------------------------
// dtcc_bit_reader
// Shared bit reader: holds the masked tail, shifts out one bit per take and
// tracks how many valid bits remain.
// ----------------------------------------------------------------------------
module dtcc_bit_reader (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dtcc_pkg::rd_ctrl_t               ctrl,
    input  logic [dtcc_pkg::TAIL_W-1:0]      tail_bits,
    input  logic [dtcc_pkg::CNT_W-1:0]       bit_count,
    output dtcc_pkg::rd_stat_t               stat
);
    import dtcc_pkg::*;

    logic [TAIL_W-1:0] word_reg;
    logic [CNT_W-1:0]  remain_reg;
    logic [TAIL_W-1:0] keep;

    // Clear bits at and above the count so a stored word sees zeros there
    always_comb begin
        for (int i = 0; i < TAIL_W; i++) begin
            keep[i] = 7'(i) < {1'b0, bit_count};
        end
    end

    // Load or shift
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            word_reg <= tail_bits & keep;
        end else if (ctrl.take) begin
            word_reg <= {1'b0, word_reg[TAIL_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else if (ctrl.load) begin
            remain_reg <= bit_count;
        end else if (ctrl.take) begin
            remain_reg <= remain_reg - 1'b1;
        end
    end

    assign stat.cur_bit = word_reg[0];
    assign stat.remain  = remain_reg;
    assign stat.word    = word_reg;

endmodule

/* src/dtcc_walker.sv */
// ----------------------------------------------------------------------------
// dtcc_walker
// Sequencer that walks block headers, stored words and fixed Huffman symbols
// at most one bit per cycle through the shared bit reader.
// ----------------------------------------------------------------------------
module dtcc_walker #(
    parameter int TAIL_LIMIT_BITS = 40
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [dtcc_pkg::CNT_W-1:0]       bit_count,
    input  logic                             out_free,
    input  dtcc_pkg::rd_stat_t               rd_stat,
    output dtcc_pkg::rd_ctrl_t               rd_ctrl,
    output dtcc_pkg::walk_stat_t             walk_stat
);
    import dtcc_pkg::*;

    localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(TAIL_LIMIT_BITS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HDR    = 4'd1;
    localparam logic [3:0] ST_STORED = 4'd2;
    localparam logic [3:0] ST_PAD    = 4'd3;
    localparam logic [3:0] ST_CHECK  = 4'd4;
    localparam logic [3:0] ST_SYM    = 4'd5;
    localparam logic [3:0] ST_LEXT   = 4'd6;
    localparam logic [3:0] ST_DIST   = 4'd7;
    localparam logic [3:0] ST_DEXT   = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0] state_reg,   state_next;
    logic [3:0] cnt_reg,     cnt_next;
    logic [8:0] code_reg,    code_next;
    logic       fin_reg,     fin_next;
    logic       typ0_reg,    typ0_next;
    logic [1:0] verdict_reg, verdict_next;

    logic [8:0]  code_shift;
    logic [3:0]  nbits;
    sym_match_t  match;
    logic [1:0]  typ;
    logic        empty;

    assign empty      = (rd_stat.remain == '0);
    assign code_shift = {code_reg[7:0], rd_stat.cur_bit};
    assign nbits      = cnt_reg + 4'd1;
    assign match      = fixed_sym(code_shift, nbits);
    assign typ        = {rd_stat.cur_bit, typ0_reg};

    // Next state
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        code_next    = code_reg;
        fin_next     = fin_reg;
        typ0_next    = typ0_reg;
        verdict_next = verdict_reg;
        rd_ctrl      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    rd_ctrl.load = 1'b1;
                    cnt_next     = '0;
                    if (bit_count == '0 || {1'b0, bit_count} >= LIMIT) begin
                        verdict_next = VERDICT_INCOMPLETE;
                        state_next   = ST_DONE;
                    end else begin
                        state_next = ST_HDR;
                    end
                end
            end

            // BFINAL then BTYPE, LSB first
            ST_HDR: begin
                if (empty) begin
                    verdict_next = VERDICT_INCOMPLETE;
                    state_next   = ST_DONE;
                end else begin
                    rd_ctrl.take = 1'b1;
                    cnt_next     = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd0) begin
                        fin_next = rd_stat.cur_bit;
                    end else if (cnt_reg == 4'd1) begin
                        typ0_next = rd_stat.cur_bit;
                    end else begin
                        cnt_next  = '0;
                        code_next = '0;
                        unique case (typ)
                            BTYPE_RESERVED: begin
                                verdict_next = VERDICT_ERROR;
                                state_next   = ST_DONE;
                            end
                            BTYPE_DYNAMIC: begin
                                verdict_next = VERDICT_INCOMPLETE;
                                state_next   = ST_DONE;
                            end
                            BTYPE_STORED: state_next = ST_STORED;
                            BTYPE_FIXED:  state_next = ST_SYM;
                        endcase
                    end
                end
            end

            // Need at least LEN/NLEN; skip up to the byte boundary
            ST_STORED: begin
                if (rd_stat.remain < STORED_MIN_BITS) begin
                    verdict_next = VERDICT_INCOMPLETE;
                    state_next   = ST_DONE;
                end else begin
                    cnt_next   = {1'b0, rd_stat.remain[2:0]};
                    state_next = ST_PAD;
                end
            end

            ST_PAD: begin
                if (cnt_reg == '0) begin
                    state_next = ST_CHECK;
                end else begin
                    rd_ctrl.take = 1'b1;
                    cnt_next     = cnt_reg - 4'd1;
                end
            end

            // Remaining bits form one word; upper bits must be zero for a match
            ST_CHECK: begin
                state_next = ST_DONE;
                if (rd_stat.word[TAIL_W-1:32] != '0 ||
                    rd_stat.word[15:0] != ~rd_stat.word[31:16]) begin
                    verdict_next = VERDICT_ERROR;
                end else if (rd_stat.word[31:0] == STORED_EMPTY) begin
                    verdict_next = VERDICT_COMPLETE;
                end else begin
                    verdict_next = VERDICT_INCOMPLETE;
                end
            end

            // Literal/length code, MSB first
            ST_SYM: begin
                if (empty) begin
                    verdict_next = VERDICT_INCOMPLETE;
                    state_next   = ST_DONE;
                end else begin
                    rd_ctrl.take = 1'b1;
                    if (match.hit) begin
                        code_next = '0;
                        cnt_next  = '0;
                        if (match.sym == SYM_END_OF_BLOCK) begin
                            if (fin_reg) begin
                                verdict_next = VERDICT_COMPLETE;
                                state_next   = ST_DONE;
                            end else begin
                                state_next = ST_HDR;
                            end
                        end else if (match.sym > SYM_LEN_MAX) begin
                            verdict_next = VERDICT_ERROR;
                            state_next   = ST_DONE;
                        end else if (match.sym > SYM_END_OF_BLOCK) begin
                            cnt_next   = length_extra(match.sym);
                            state_next = ST_LEXT;
                        end
                    end else if (nbits == 4'd9) begin
                        verdict_next = VERDICT_ERROR;
                        state_next   = ST_DONE;
                    end else begin
                        code_next = code_shift;
                        cnt_next  = nbits;
                    end
                end
            end

            ST_LEXT: begin
                if (cnt_reg == '0) begin
                    code_next  = '0;
                    state_next = ST_DIST;
                end else if (empty) begin
                    verdict_next = VERDICT_INCOMPLETE;
                    state_next   = ST_DONE;
                end else begin
                    rd_ctrl.take = 1'b1;
                    cnt_next     = cnt_reg - 4'd1;
                end
            end

            // Five-bit distance code, MSB first
            ST_DIST: begin
                if (empty) begin
                    verdict_next = VERDICT_INCOMPLETE;
                    state_next   = ST_DONE;
                end else begin
                    rd_ctrl.take = 1'b1;
                    code_next    = code_shift;
                    cnt_next     = nbits;
                    if (cnt_reg == 4'd4) begin
                        if (code_shift[4:0] > DIST_CODE_MAX) begin
                            verdict_next = VERDICT_ERROR;
                            state_next   = ST_DONE;
                        end else begin
                            cnt_next   = dist_extra(code_shift[4:0]);
                            state_next = ST_DEXT;
                        end
                    end
                end
            end

            ST_DEXT: begin
                if (cnt_reg == '0) begin
                    code_next  = '0;
                    state_next = ST_SYM;
                end else if (empty) begin
                    verdict_next = VERDICT_INCOMPLETE;
                    state_next   = ST_DONE;
                end else begin
                    rd_ctrl.take = 1'b1;
                    cnt_next     = cnt_reg - 4'd1;
                end
            end

            // Hold the verdict until the output register can take it
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        code_reg    <= code_next;
        fin_reg     <= fin_next;
        typ0_reg    <= typ0_next;
        verdict_reg <= verdict_next;
    end

    assign walk_stat.idle    = (state_reg == ST_IDLE);
    assign walk_stat.done    = (state_reg == ST_DONE) && out_free;
    assign walk_stat.verdict = verdict_reg;

endmodule

/* src/deflate_tail_completeness_check.sv */
// ----------------------------------------------------------------------------
// deflate_tail_completeness_check
// Judges whether the leftover tail bits of a deflate stream end in complete
// final blocks, need more data, or are malformed.
//
//  channel | dir | tdata fields (low bit up)                 | tuser
//  s_      | in  | tail_bits[38:0], bit_count[44:39], pad    | none
//  m_      | out | verdict[1:0], pad                          | none
//
//  The walker reads tail bits through the shared bit reader, at most one
//  bit per cycle. An item passes through a load, the bit reads, an extra
//  step after the extra bits of each length and each distance, the closing
//  states and a done state. Input is accepted only while the walker is idle.
//  The result sits in an output register, so a new item may enter while the
//  previous verdict waits. A finished verdict holds in the walker while that
//  register is full.
//  Reset (aresetn low, synchronous) returns the walker to idle and empties
//  the output register.
// ----------------------------------------------------------------------------
module deflate_tail_completeness_check #(
    parameter int TAIL_LIMIT_BITS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // tail_bits[38:0], bit_count[44:39], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // verdict[1:0], zeros
);
    import dtcc_pkg::*;

    rd_ctrl_t   rd_ctrl;
    rd_stat_t   rd_stat;
    walk_stat_t walk_stat;

    logic              start;
    logic              out_free;
    logic              out_valid_reg;
    logic [1:0]        out_verdict_reg;
    logic [TAIL_W-1:0] tail_bits;
    logic [CNT_W-1:0]  bit_count;

    assign tail_bits = s_tdata[TAIL_W-1:0];
    assign bit_count = s_tdata[TAIL_W+CNT_W-1:TAIL_W];
    assign s_tready  = walk_stat.idle;
    assign start     = s_tvalid && walk_stat.idle;
    assign out_free  = !out_valid_reg || m_tready;

    dtcc_bit_reader u_reader (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rd_ctrl),
        .tail_bits (tail_bits),
        .bit_count (bit_count),
        .stat      (rd_stat)
    );

    dtcc_walker #(
        .TAIL_LIMIT_BITS (TAIL_LIMIT_BITS)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .bit_count (bit_count),
        .out_free  (out_free),
        .rd_stat   (rd_stat),
        .rd_ctrl   (rd_ctrl),
        .walk_stat (walk_stat)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (walk_stat.done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_stat.done) begin
            out_verdict_reg <= walk_stat.verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_verdict_reg};

endmodule

/* src/dtcc_checker.sv */
// ----------------------------------------------------------------------------
// dtcc_checker
// Port-level checks on the tail completeness check, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtcc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import dtcc_pkg::*;

    // Only the three defined verdicts, upper bits zero
    `ASSERT_CLK(a_verdict_legal, aclk, aresetn, m_tvalid |-> (m_tdata[7:2] == '0 && m_tdata[1:0] <= VERDICT_ERROR))

    // The walker needs cycles per item, so input closes after a transfer
    `ASSERT_CLK(a_busy_after_take, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)

    // A stalled result holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // Reset empties the output and leaves the input open
    `ASSERT_CLK_ALWAYS(a_reset_state, aclk, !aresetn |=> (!m_tvalid && s_tready))

endmodule

bind deflate_tail_completeness_check dtcc_checker u_dtcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
